### rtl/set_assoc_lru_cache_tags_unit_macros.svh
// assertion helpers used by the checker file
`ifndef SET_ASSOC_LRU_CACHE_TAGS_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SALC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true outside reset
`define SALC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

### rtl/salc_pkg.sv
package salc_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 32;
  localparam int SETS         = 1 << MAX_SET_BITS;
  localparam int SET_W        = MAX_SET_BITS;
  localparam int WAY_W        = $clog2(MAX_WAYS);
  localparam int TAG_W        = 32;
  localparam int STAMP_W      = 32;
  localparam int CNT_W        = 32;
  localparam int SBITS_W      = 4;
  localparam int WAYS_CFG_W   = 4;
  localparam int OFF_W        = 5;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int REQ_W        = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS = 2'd0,
    CFG_WAYS     = 2'd1,
    CFG_OFFSET   = 2'd2
  } cfg_idx_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_STORE  = 2'd1,
    REQ_MODIFY = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  // one memory row holds a whole set
  typedef struct packed {
    logic [MAX_WAYS-1:0]              valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp;
  } row_t;

  // candidate in the lru search tree
  typedef struct packed {
    logic               en;
    logic [STAMP_W-1:0] stamp;
    logic [WAY_W-1:0]   idx;
  } node_t;

  // older stamp wins, lower way (a) wins on a tie
  function automatic node_t node_min(node_t a, node_t b);
    node_t r;
    if (b.en && (!a.en || (b.stamp < a.stamp))) r = b;
    else r = a;
    return r;
  endfunction

endpackage

### rtl/set_assoc_lru_cache_tags_unit.sv
// Tag store of a set-associative cache with LRU replacement. Each request is a load, store or
// modify at a byte address; one result per request gives hit/miss/eviction flags and running
// totals. A set lives in one row of a single-port memory (256 rows, all ways side by side), so
// a request goes through these steps: row read at acceptance, tag compare with the first level
// of the stamp search, then the rest of the search and the row write-back, which also registers
// the result. The next request is taken once the block is back in idle after the write-back, so
// no new request is accepted while one is in flight. A row-valid flop per set replaces a clearing
// pass, so the block accepts requests right after reset. Result is held in an output register;
// a stalled result holds the block in its write-back step.
module set_assoc_lru_cache_tags_unit
  import salc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [ADDR_WIDTH-1:0] in_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_was_hit,
  output logic                  out_was_miss,
  output logic                  out_was_eviction,
  output logic                  out_extra_hit,
  output logic [CNT_W-1:0]      out_hits_total,
  output logic [CNT_W-1:0]      out_misses_total,
  output logic [CNT_W-1:0]      out_evictions_total
);

  // configuration
  logic [SBITS_W-1:0]    set_bits_r;
  logic [WAYS_CFG_W-1:0] ways_r;
  logic [OFF_W-1:0]      off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= SBITS_W'(4);
      ways_r     <= WAYS_CFG_W'(1);
      off_r      <= OFF_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS: set_bits_r <= cfg_wdata[SBITS_W-1:0];
        CFG_WAYS:     ways_r     <= cfg_wdata[WAYS_CFG_W-1:0];
        CFG_OFFSET:   off_r      <= cfg_wdata[OFF_W-1:0];
        default:      ;
      endcase
    end
  end

  // address split
  logic [SBITS_W-1:0]    sbits_eff;
  logic [WAYS_CFG_W-1:0] ways_eff;
  logic [ADDR_WIDTH-1:0] block_addr;
  logic [SET_W:0]        set_mask;
  logic [SET_W-1:0]      rd_set;
  logic [TAG_W-1:0]      in_tag;
  logic [MAX_WAYS-1:0]   way_en;

  always_comb begin
    sbits_eff  = (set_bits_r > SBITS_W'(MAX_SET_BITS)) ? SBITS_W'(MAX_SET_BITS) : set_bits_r;
    if (ways_r == '0) ways_eff = WAYS_CFG_W'(1);
    else if (ways_r > WAYS_CFG_W'(MAX_WAYS)) ways_eff = WAYS_CFG_W'(MAX_WAYS);
    else ways_eff = ways_r;
    block_addr = in_address >> off_r;
    set_mask   = ((SET_W+1)'(1) << sbits_eff) - (SET_W+1)'(1);
    rd_set     = block_addr[SET_W-1:0] & set_mask[SET_W-1:0];
    in_tag     = TAG_W'(block_addr >> sbits_eff);
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w] = WAYS_CFG_W'(w) < ways_eff;
    end
  end

  // control
  state_t state_r, state_nxt;
  logic   rd_en;
  logic   do_upd;
  logic   out_free;
  logic   out_valid_r;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    do_upd   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
      end
      ST_UPD:  do_upd = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // set memory and per-row valid flops
  row_t             mem [SETS];
  row_t             rd_row_r;
  row_t             wr_row;
  logic [SETS-1:0]  row_valid_r;
  logic             rv_r;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic [REQ_W-1:0] req_r;
  logic [MAX_WAYS-1:0] en_r;

  always_ff @(posedge clk) begin
    if (do_upd) mem[set_r] <= wr_row;
    if (rd_en) rd_row_r <= mem[rd_set];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_valid_r <= '0;
    else if (do_upd) row_valid_r[set_r] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rv_r  <= row_valid_r[rd_set];
      set_r <= rd_set;
      tag_r <= in_tag;
      req_r <= in_req_type;
      en_r  <= way_en;
    end
  end

  // compare step: hit search, first free way, first level of lru tree
  logic [MAX_WAYS-1:0] cur_valid;
  logic                hit_c, free_c;
  logic [WAY_W-1:0]    hit_way_c, free_way_c;
  node_t               l1_c [MAX_WAYS/2];
  node_t               na, nb;

  always_comb begin
    cur_valid  = rv_r ? rd_row_r.valid : '0;
    hit_c      = 1'b0;
    hit_way_c  = '0;
    free_c     = 1'b0;
    free_way_c = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit_c && en_r[w] && cur_valid[w] && (rd_row_r.tag[w] == tag_r)) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(w);
      end
      if (!free_c && en_r[w] && !cur_valid[w]) begin
        free_c     = 1'b1;
        free_way_c = WAY_W'(w);
      end
    end
    for (int j = 0; j < MAX_WAYS/2; j++) begin
      na = '{en: en_r[2*j], stamp: rd_row_r.stamp[2*j], idx: WAY_W'(2*j)};
      nb = '{en: en_r[2*j+1], stamp: rd_row_r.stamp[2*j+1], idx: WAY_W'(2*j+1)};
      l1_c[j] = node_min(na, nb);
    end
  end

  logic             hit_r, free_r;
  logic [WAY_W-1:0] hit_way_r, free_way_r;
  node_t            l1_r [MAX_WAYS/2];

  always_ff @(posedge clk) begin
    if (state_r == ST_CMP) begin
      hit_r      <= hit_c;
      hit_way_r  <= hit_way_c;
      free_r     <= free_c;
      free_way_r <= free_way_c;
      l1_r       <= l1_c;
    end
  end

  // update step: finish lru search, build row, bump counters
  node_t            l2_c [MAX_WAYS/4];
  node_t            victim;
  logic [WAY_W-1:0] fill_way;
  logic             evict;
  logic             is_mod;

  always_comb begin
    for (int j = 0; j < MAX_WAYS/4; j++) begin
      l2_c[j] = node_min(l1_r[2*j], l1_r[2*j+1]);
    end
    victim = l2_c[0];
    for (int j = 1; j < MAX_WAYS/4; j++) begin
      victim = node_min(victim, l2_c[j]);
    end
    evict    = !hit_r && !free_r;
    if (hit_r) fill_way = hit_way_r;
    else if (free_r) fill_way = free_way_r;
    else fill_way = victim.idx;
    is_mod   = req_r == REQ_MODIFY;
  end

  logic [STAMP_W-1:0] clock_r;
  logic [CNT_W-1:0]   hits_r, misses_r, evs_r;
  logic [CNT_W-1:0]   hits_nxt, misses_nxt, evs_nxt;

  always_comb begin
    wr_row                 = rd_row_r;
    wr_row.valid           = cur_valid;
    wr_row.valid[fill_way] = 1'b1;
    wr_row.tag[fill_way]   = tag_r;
    wr_row.stamp[fill_way] = clock_r;
    hits_nxt   = hits_r + CNT_W'(hit_r) + CNT_W'(is_mod);
    misses_nxt = misses_r + CNT_W'(!hit_r);
    evs_nxt    = evs_r + CNT_W'(evict);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evs_r    <= '0;
    end else if (do_upd) begin
      clock_r  <= clock_r + STAMP_W'(1);
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evs_r    <= evs_nxt;
    end
  end

  // result register
  logic             was_hit_r, was_evict_r, extra_hit_r;
  logic [CNT_W-1:0] out_hits_r, out_misses_r, out_evs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (do_upd) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (do_upd) begin
      was_hit_r    <= hit_r;
      was_evict_r  <= evict;
      extra_hit_r  <= is_mod;
      out_hits_r   <= hits_nxt;
      out_misses_r <= misses_nxt;
      out_evs_r    <= evs_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_was_hit         = was_hit_r;
  assign out_was_miss        = !was_hit_r;
  assign out_was_eviction    = was_evict_r;
  assign out_extra_hit       = extra_hit_r;
  assign out_hits_total      = out_hits_r;
  assign out_misses_total    = out_misses_r;
  assign out_evictions_total = out_evs_r;

endmodule

### rtl/salc_checker.sv
`include "set_assoc_lru_cache_tags_unit_macros.svh"

module salc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_was_hit,
  input logic        out_was_miss,
  input logic        out_was_eviction,
  input logic [31:0] out_hits_total
);

  // a stalled result stays valid and keeps its hit flag and hits total
  `SALC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_hits_total) && $stable(out_was_hit), "result changed while stalled")

  `SALC_ASSERT(a_hit_xor_miss, out_valid |-> out_was_hit != out_was_miss, "hit and miss flags disagree")

  `SALC_ASSERT_NEVER(a_evict_on_hit, out_valid && out_was_eviction && out_was_hit, "eviction reported on a hit")

  // one request at a time: busy right after an accept
  `SALC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "request taken while busy")

endmodule

bind set_assoc_lru_cache_tags_unit salc_checker u_salc_checker (.*);
